### rtl/drs_pkg.sv
`default_nettype none

package drs_pkg;

   localparam int DEF_QUEUE_DEPTH = 32;
   localparam int DEF_TRACK_BITS  = 16;
   localparam int ID_BITS         = 16;
   localparam int POLICY_BITS     = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 2;

   localparam logic [POLICY_BITS-1:0] POL_FIFO  = 3'd0;
   localparam logic [POLICY_BITS-1:0] POL_SSTF  = 3'd1;
   localparam logic [POLICY_BITS-1:0] POL_LOOK  = 3'd2;
   localparam logic [POLICY_BITS-1:0] POL_CLOOK = 3'd3;
   localparam logic [POLICY_BITS-1:0] POL_FLOOK = 3'd4;

   localparam logic OP_ENQUEUE  = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   typedef enum logic [1:0] {
      STAT_ENQUEUED   = 2'd0,
      STAT_FULL       = 2'd1,
      STAT_DISPATCHED = 2'd2,
      STAT_EMPTY      = 2'd3
   } status_type;

endpackage

`default_nettype wire

### rtl/drs_ram.sv
`default_nettype none

module drs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/drs_scan.sv
`default_nettype none

module drs_scan #(
   parameter int QUEUE_DEPTH = drs_pkg::DEF_QUEUE_DEPTH,
   parameter int TRACK_BITS  = drs_pkg::DEF_TRACK_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  start,
   input  wire logic                                  data_valid,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0]        data_idx,
   input  wire logic [drs_pkg::ID_BITS-1:0]           data_id,
   input  wire logic [TRACK_BITS-1:0]                 data_trk,
   input  wire logic [TRACK_BITS-1:0]                 head,
   input  wire logic [drs_pkg::POLICY_BITS-1:0]       policy,
   input  wire logic                                  sweep_up,
   output logic      [$clog2(QUEUE_DEPTH)-1:0]        pick_idx,
   output logic      [drs_pkg::ID_BITS-1:0]           pick_id,
   output logic      [TRACK_BITS-1:0]                 pick_trk,
   output logic                                       sweep_flip
);

   import drs_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);

   // One running candidate per selection rule; strict compares keep the oldest on ties.
   logic                  first_hit_ff, abs_hit_ff, ge_hit_ff, le_hit_ff, low_hit_ff;
   logic [TRACK_BITS-1:0] abs_dist_ff, ge_dist_ff, le_dist_ff;
   logic [IW-1:0]         first_idx_ff, abs_idx_ff, ge_idx_ff, le_idx_ff, low_idx_ff;
   logic [ID_BITS-1:0]    first_id_ff, abs_id_ff, ge_id_ff, le_id_ff, low_id_ff;
   logic [TRACK_BITS-1:0] first_trk_ff, abs_trk_ff, ge_trk_ff, le_trk_ff, low_trk_ff;

   logic [TRACK_BITS-1:0] d_up, d_dn, d_abs;
   logic                  at_or_above, at_or_below;

   assign d_up        = data_trk - head;
   assign d_dn        = head - data_trk;
   assign at_or_above = data_trk >= head;
   assign at_or_below = data_trk <= head;
   assign d_abs       = at_or_above ? d_up : d_dn;

   always_ff @(posedge clock) begin
      if (start) begin
         first_hit_ff <= 1'b0;
         abs_hit_ff   <= 1'b0;
         ge_hit_ff    <= 1'b0;
         le_hit_ff    <= 1'b0;
         low_hit_ff   <= 1'b0;
      end else if (data_valid) begin
         if (!first_hit_ff) begin
            first_hit_ff <= 1'b1;
            first_idx_ff <= data_idx;
            first_id_ff  <= data_id;
            first_trk_ff <= data_trk;
         end
         if (!abs_hit_ff || d_abs < abs_dist_ff) begin
            abs_hit_ff  <= 1'b1;
            abs_dist_ff <= d_abs;
            abs_idx_ff  <= data_idx;
            abs_id_ff   <= data_id;
            abs_trk_ff  <= data_trk;
         end
         if (at_or_above && (!ge_hit_ff || d_up < ge_dist_ff)) begin
            ge_hit_ff  <= 1'b1;
            ge_dist_ff <= d_up;
            ge_idx_ff  <= data_idx;
            ge_id_ff   <= data_id;
            ge_trk_ff  <= data_trk;
         end
         if (at_or_below && (!le_hit_ff || d_dn < le_dist_ff)) begin
            le_hit_ff  <= 1'b1;
            le_dist_ff <= d_dn;
            le_idx_ff  <= data_idx;
            le_id_ff   <= data_id;
            le_trk_ff  <= data_trk;
         end
         if (!low_hit_ff || data_trk < low_trk_ff) begin
            low_hit_ff <= 1'b1;
            low_idx_ff <= data_idx;
            low_id_ff  <= data_id;
            low_trk_ff <= data_trk;
         end
      end
   end

   logic use_ge;

   always_comb begin
      sweep_flip = 1'b0;
      use_ge     = 1'b0;
      pick_idx   = first_idx_ff;
      pick_id    = first_id_ff;
      pick_trk   = first_trk_ff;
      case (policy)
         POL_SSTF: begin
            pick_idx = abs_idx_ff;
            pick_id  = abs_id_ff;
            pick_trk = abs_trk_ff;
         end
         POL_LOOK, POL_FLOOK: begin
            if (sweep_up) begin
               use_ge     = ge_hit_ff;
               sweep_flip = !ge_hit_ff;
            end else begin
               use_ge     = !le_hit_ff;
               sweep_flip = !le_hit_ff;
            end
            if (use_ge) begin
               pick_idx = ge_idx_ff;
               pick_id  = ge_id_ff;
               pick_trk = ge_trk_ff;
            end else begin
               pick_idx = le_idx_ff;
               pick_id  = le_id_ff;
               pick_trk = le_trk_ff;
            end
         end
         POL_CLOOK: begin
            if (ge_hit_ff) begin
               pick_idx = ge_idx_ff;
               pick_id  = ge_id_ff;
               pick_trk = ge_trk_ff;
            end else begin
               pick_idx = low_idx_ff;
               pick_id  = low_id_ff;
               pick_trk = low_trk_ff;
            end
         end
         default: begin
            pick_idx = first_idx_ff;
            pick_id  = first_id_ff;
            pick_trk = first_trk_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/disk_request_scheduler.sv
`default_nettype none
// Channel   Handshake                 Payload
// req       req_valid / req_ready     req_operation, req_request_id, req_track,
//                                     req_head_position
// rsp       rsp_valid / rsp_ready     rsp_status, rsp_grant_id, rsp_grant_track
// csr       psel/penable/pwrite/pready paddr, pwdata, prdata (policy register)
//
// An enqueue or an empty dispatch goes from S_IDLE straight to S_DONE, which
// passes the result to the output register once that register is free. A dispatch
// reads every entry once to scan it, then reads each entry after the chosen one
// again to shift it one place lower, all through the single read port of the
// queue memory.
// Reset clears the counts and the policy and sets the sweep direction up; the
// queue memory is not cleared. A request is taken only while no other is in work.

module disk_request_scheduler #(
   parameter int QUEUE_DEPTH = drs_pkg::DEF_QUEUE_DEPTH,
   parameter int TRACK_BITS  = drs_pkg::DEF_TRACK_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_operation,
   input  wire logic [drs_pkg::ID_BITS-1:0]         req_request_id,
   input  wire logic [TRACK_BITS-1:0]               req_track,
   input  wire logic [TRACK_BITS-1:0]               req_head_position,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [1:0]                          rsp_status,
   output logic      [drs_pkg::ID_BITS-1:0]         rsp_grant_id,
   output logic      [TRACK_BITS-1:0]               rsp_grant_track,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [drs_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [drs_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [drs_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready
);

   import drs_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = IW + 1;
   localparam int EW = ID_BITS + TRACK_BITS;
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [POLICY_BITS-1:0] policy_ff, policy_in;
   logic [CW-1:0]         act_count_ff, act_count_in;
   logic [CW-1:0]         pend_count_ff, pend_count_in;
   logic                  bank_ff, bank_in;
   logic                  sweep_up_ff, sweep_up_in;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic                  tag_valid_ff, tag_valid_in;
   logic [IW-1:0]         tag_idx_ff, tag_idx_in;
   status_type            res_status_ff, res_status_in;
   logic [ID_BITS-1:0]    res_id_ff, res_id_in;
   logic [TRACK_BITS-1:0] res_trk_ff, res_trk_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [TRACK_BITS-1:0] rsp_trk_ff, rsp_trk_in;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [EW-1:0]         ram_wdata, ram_rdata;

   logic                  scan_start;
   logic [IW-1:0]         pick_idx;
   logic [ID_BITS-1:0]    pick_id;
   logic [TRACK_BITS-1:0] pick_trk;
   logic                  sweep_flip;

   logic [CW-1:0]         ptr_dec, pick_next, cnt_left, enq_count;
   logic                  enq_pending;
   logic                  csr_write;

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr == '0) ? CSR_DATA_BITS'(policy_ff) : '0;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_grant_id    = rsp_id_ff;
   assign rsp_grant_track = rsp_trk_ff;

   assign ptr_dec     = ptr_ff - CW'(1);
   assign pick_next   = CW'(pick_idx) + CW'(1);
   assign cnt_left    = act_count_ff - CW'(1);
   assign enq_pending = (policy_ff == POL_FLOOK);
   assign enq_count   = enq_pending ? pend_count_ff : act_count_ff;

   drs_ram #(
      .WIDTH(EW),
      .DEPTH(2 << IW)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   drs_scan #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TRACK_BITS (TRACK_BITS)
   ) u_scan (
      .clock     (clock),
      .start     (scan_start),
      .data_valid(tag_valid_ff && (state_ff == S_SCAN)),
      .data_idx  (tag_idx_ff),
      .data_id   (ram_rdata[EW-1:TRACK_BITS]),
      .data_trk  (ram_rdata[TRACK_BITS-1:0]),
      .head      (head_ff),
      .policy    (policy_ff),
      .sweep_up  (sweep_up_ff),
      .pick_idx  (pick_idx),
      .pick_id   (pick_id),
      .pick_trk  (pick_trk),
      .sweep_flip(sweep_flip)
   );

   always_comb begin
      state_in      = state_ff;
      policy_in     = csr_write ? pwdata[POLICY_BITS-1:0] : policy_ff;
      act_count_in  = act_count_ff;
      pend_count_in = pend_count_ff;
      bank_in       = bank_ff;
      sweep_up_in   = sweep_up_ff;
      head_in       = head_ff;
      ptr_in        = ptr_ff;
      tag_valid_in  = 1'b0;
      tag_idx_in    = tag_idx_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_trk_in    = res_trk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_trk_in    = rsp_trk_ff;
      ram_we        = 1'b0;
      ram_waddr     = {bank_ff, tag_idx_ff};
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = {bank_ff, ptr_ff[IW-1:0]};
      scan_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_id_in  = '0;
               res_trk_in = '0;
               head_in    = req_head_position;
               state_in   = S_DONE;
               if (req_operation == OP_ENQUEUE) begin
                  if (enq_count >= FULL_COUNT) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     res_status_in = STAT_ENQUEUED;
                     ram_we        = 1'b1;
                     ram_waddr     = {bank_ff ^ enq_pending, enq_count[IW-1:0]};
                     ram_wdata     = {req_request_id, req_track};
                     if (enq_pending) begin
                        pend_count_in = pend_count_ff + CW'(1);
                     end else begin
                        act_count_in = act_count_ff + CW'(1);
                     end
                  end
               end else if (act_count_ff == '0 &&
                            !(enq_pending && pend_count_ff != '0)) begin
                  res_status_in = STAT_EMPTY;
               end else begin
                  // Under FLOOK an empty active queue takes over the pending one.
                  if (act_count_ff == '0) begin
                     bank_in       = !bank_ff;
                     act_count_in  = pend_count_ff;
                     pend_count_in = '0;
                  end
                  ptr_in     = '0;
                  scan_start = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ptr_ff < act_count_ff) begin
               ram_re       = 1'b1;
               tag_valid_in = 1'b1;
               tag_idx_in   = ptr_ff[IW-1:0];
               ptr_in       = ptr_ff + CW'(1);
            end else if (!tag_valid_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_status_in = STAT_DISPATCHED;
            res_id_in     = pick_id;
            res_trk_in    = pick_trk;
            sweep_up_in   = sweep_up_ff ^ sweep_flip;
            ptr_in        = pick_next;
            state_in      = S_SHIFT;
         end
         S_SHIFT: begin
            // Each later entry is read and written back one place lower.
            if (tag_valid_ff) begin
               ram_we = 1'b1;
            end
            if (ptr_ff < act_count_ff) begin
               ram_re       = 1'b1;
               tag_valid_in = 1'b1;
               tag_idx_in   = ptr_dec[IW-1:0];
               ptr_in       = ptr_ff + CW'(1);
            end else if (!tag_valid_ff) begin
               state_in = S_DONE;
               if (enq_pending && cnt_left == '0 && pend_count_ff != '0) begin
                  bank_in       = !bank_ff;
                  act_count_in  = pend_count_ff;
                  pend_count_in = '0;
               end else begin
                  act_count_in = cnt_left;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_trk_in    = res_trk_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         policy_ff     <= POL_FIFO;
         act_count_ff  <= '0;
         pend_count_ff <= '0;
         bank_ff       <= 1'b0;
         sweep_up_ff   <= 1'b1;
         tag_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         act_count_ff  <= act_count_in;
         pend_count_ff <= pend_count_in;
         bank_ff       <= bank_in;
         sweep_up_ff   <= sweep_up_in;
         tag_valid_ff  <= tag_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      head_ff       <= head_in;
      ptr_ff        <= ptr_in;
      tag_idx_ff    <= tag_idx_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_trk_ff    <= res_trk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_trk_ff    <= rsp_trk_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      act_count_ff <= FULL_COUNT && pend_count_ff <= FULL_COUNT)
      else $error("queue count exceeds the queue depth");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted request left no work in progress");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && tag_valid_ff) |-> (CW'(tag_idx_ff) < cnt_left))
      else $error("shift writes beyond the remaining entries");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> (CW'(pick_idx) < act_count_ff))
      else $error("selected entry lies outside the active queue");

endmodule

`default_nettype wire
